FILE: hw/rtl/bwcap_pkg.sv
// Shared types and constants for the credit-capped bandwidth limiter.
`default_nettype none
package bwcap_pkg;

  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned CREDIT_CAP_MS = 10000;

  // The first division works through the whole 64-bit total.
  localparam int unsigned DIV1_STEPS = TIME_W;
  // The remainder times 1000 stays below 2^42, so the second division needs 42 steps.
  localparam int unsigned R1000_W = LIMIT_W + 10;
  localparam int unsigned DIV2_STEPS = R1000_W;
  localparam int unsigned DIV2_PAD = TIME_W - R1000_W;
  localparam int unsigned CNT_W = $clog2(DIV1_STEPS + 1);
  // The sub-second part of the target time is always below 1000.
  localparam int unsigned PART_W = 10;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_XFER = 1'b1;

  typedef struct packed {
    logic tick;       // advance the millisecond clock
    logic xfer;       // add the byte count and load the first division
    logic div_step;   // one restoring division step
    logic mul;        // scale the quotient and load the second division
    logic eta;        // form the target time and the elapsed time
    logic bound;      // form the target plus the credit cap
    logic cap;        // clamp the unused credit
    logic out_load;   // load the output register
    logic out_zero;   // the loaded delay is zero (limiting disabled)
  } cmd_t;

  typedef struct packed {
    logic limit_zero; // the rate limit register holds zero
    logic div_last;   // the current division step is the final one
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bandwidth_limiter_credit_cap_core.sv
// Top level of the credit-capped bandwidth limiter: controller plus datapath.
// A tick request produces no result and leaves the block in idle; the block is ready again next cycle.
// A transfer with limiting enabled is accepted, runs 64 steps of the one-bit-per-cycle restoring
// divider, is scaled, runs 42 more steps, and then forms the target, the cap and the delay; the
// result loads once the output register is free. A zero-limit transfer goes straight to delivery.
// Synchronous active-low reset clears the clock, start time, byte total, limit and all control.
`default_nettype none
module bandwidth_limiter_credit_cap_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: the rate limit in bytes per second, zero disables limiting.
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] byte_count
  input  wire logic [0:0]  in_tuser,   // [0] kind: 0 = millisecond tick, 1 = transfer
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // [63:0] delay_ms
);
  import bwcap_pkg::*;

  // Command and status between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request: ticks are handled directly in the idle
  // state, while a transfer with a nonzero limit walks through the two divisions and the cap logic.
  // The result sits in an output register, so a new request is taken while the
  // previous result still waits on the result channel.
  bwcap_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the millisecond clock, start time, byte total and the limit,
  // computes the target time as whole seconds times 1000 plus the scaled remainder
  // over the limit, and clamps any unused credit to the cap.
  bwcap_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_byte_count (in_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .delay_ms      (out_tdata)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/bwcap_datapath.sv
// Datapath of the bandwidth limiter: time and byte state, divider and delay register.
`default_nettype none
module bwcap_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bwcap_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire logic [bwcap_pkg::BYTES_W-1:0] in_byte_count,
  input  wire bwcap_pkg::cmd_t               cmd,
  output bwcap_pkg::sts_t                    sts,
  output logic [bwcap_pkg::TIME_W-1:0]       delay_ms
);
  import bwcap_pkg::*;

  logic [LIMIT_W-1:0] rate_limit_r;
  logic [TIME_W-1:0]  clock_r;
  logic [TIME_W-1:0]  start_r;
  logic [TIME_W-1:0]  total_r;
  logic [TIME_W-1:0]  total_nxt;

  logic [TIME_W-1:0]  quo_r;
  logic [LIMIT_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TIME_W-1:0]  whole_r;
  logic [TIME_W-1:0]  eta_r;
  logic [TIME_W-1:0]  elapsed_r;
  logic [TIME_W-1:0]  bound_r;
  logic [TIME_W-1:0]  delay_r;

  logic [LIMIT_W:0]   trial;
  logic               fits;
  logic [LIMIT_W:0]   trial_sub;
  logic [TIME_W-1:0]  whole_nxt;
  logic [R1000_W-1:0] r1000;

  assign total_nxt = total_r + {{(TIME_W-BYTES_W){1'b0}}, in_byte_count};

  // Restoring division: shift one dividend bit into the partial remainder.
  assign trial     = {rem_r, quo_r[TIME_W-1]};
  assign fits      = (trial >= {1'b0, rate_limit_r});
  assign trial_sub = trial - {1'b0, rate_limit_r};

  // Multiplications by 1000 as 1024 - 16 - 8.
  assign whole_nxt = (quo_r << 10) - (quo_r << 4) - (quo_r << 3);
  assign r1000 = ({{(R1000_W-LIMIT_W){1'b0}}, rem_r} << 10)
               - ({{(R1000_W-LIMIT_W){1'b0}}, rem_r} << 4)
               - ({{(R1000_W-LIMIT_W){1'b0}}, rem_r} << 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r <= '0;
      clock_r      <= '0;
      start_r      <= '0;
      total_r      <= '0;
    end else begin
      if (cfg_we) begin
        rate_limit_r <= cfg_wdata;
      end
      if (cmd.tick) begin
        clock_r <= clock_r + TIME_W'(1);
      end
      if (cmd.xfer) begin
        total_r <= total_nxt;
      end
      if (cmd.cap && (elapsed_r > bound_r)) begin
        start_r <= clock_r - bound_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xfer) begin
      quo_r <= total_nxt;
      rem_r <= '0;
      cnt_r <= CNT_W'(DIV1_STEPS);
    end else if (cmd.mul) begin
      whole_r <= whole_nxt;
      quo_r   <= {r1000, {DIV2_PAD{1'b0}}};
      rem_r   <= '0;
      cnt_r   <= CNT_W'(DIV2_STEPS);
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[TIME_W-2:0], fits};
      rem_r <= fits ? trial_sub[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.eta) begin
      eta_r     <= whole_r + {{(TIME_W-PART_W){1'b0}}, quo_r[PART_W-1:0]};
      elapsed_r <= clock_r - start_r;
    end
    if (cmd.bound) begin
      bound_r <= eta_r + TIME_W'(CREDIT_CAP_MS);
    end
    if (cmd.cap && (elapsed_r > bound_r)) begin
      elapsed_r <= bound_r;
    end
    if (cmd.out_load) begin
      if (cmd.out_zero || !(eta_r > elapsed_r)) begin
        delay_r <= '0;
      end else begin
        delay_r <= eta_r - elapsed_r;
      end
    end
  end

  assign sts.limit_zero = (rate_limit_r == '0);
  assign sts.div_last   = (cnt_r == CNT_W'(1));
  assign delay_ms       = delay_r;

  // After the clamp the elapsed time never runs past the capped target.
  a_cap_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> (elapsed_r <= bound_r))
    else $error("elapsed time exceeds capped target after clamp");

  // A division step always runs with a nonzero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !sts.limit_zero)
    else $error("division step with zero rate limit");

  // The scaled remainder over the limit is always a sub-second amount.
  a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eta |-> (quo_r < TIME_W'(MS_PER_SEC)))
    else $error("sub-second part of the target time out of range");

endmodule
`default_nettype wire

FILE: hw/rtl/bwcap_ctrl.sv
// Controller state machine of the bandwidth limiter.
`default_nettype none
module bwcap_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic           in_kind,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire bwcap_pkg::sts_t sts,
  output bwcap_pkg::cmd_t     cmd
);
  import bwcap_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_ETA  = 3'd4;
  localparam logic [2:0] S_BND  = 3'd5;
  localparam logic [2:0] S_CAP  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       zero_r;
  logic       zero_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    zero_nxt  = zero_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_TICK) begin
            cmd.tick = 1'b1;
          end else if (sts.limit_zero) begin
            zero_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.xfer  = 1'b1;
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ETA;
        end
      end
      S_ETA: begin
        cmd.eta   = 1'b1;
        state_nxt = S_BND;
      end
      S_BND: begin
        cmd.bound = 1'b1;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = zero_r;
          zero_nxt     = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        zero_nxt  = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // The output register is only overwritten once its request has been taken.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while still pending");

  // The first division hands over to the scaling step.
  a_div1_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 && sts.div_last) |=> (state_r == S_MUL))
    else $error("first division did not finish into scaling");

  // A tick never leaves the idle state.
  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_TICK) |=> (state_r == S_IDLE))
    else $error("tick request left the idle state");

  // The zero-delay flag only lives while waiting to deliver.
  a_zero_done: assert property (@(posedge clk) disable iff (!rst_n)
    zero_r |-> (state_r == S_DONE))
    else $error("zero-delay flag set outside the delivery state");

endmodule
`default_nettype wire

FILE: test/tb_bandwidth_limiter_credit_cap_core.sv
// Self-checking testbench for the credit-capped bandwidth limiter core.
`timescale 1ns / 100ps

class delay_scoreboard;
  // Shadow copy of the limiter's state and its one register.
  bit [63:0] now_ms;
  bit [63:0] origin_ms;
  bit [63:0] bytes_sent;
  bit [31:0] rate;
  // Owed delays that the block has yet to return, oldest first.
  bit [63:0] owed_delays[$];
  int unsigned errors;

  function new();
    now_ms = '0;
    origin_ms = '0;
    bytes_sent = '0;
    rate = '0;
    errors = 0;
  endfunction

  function void set_limit(bit [31:0] value);
    rate = value;
  endfunction

  function int pending();
    return owed_delays.size();
  endfunction

  // Milliseconds by which the given byte total should have been sent.
  function bit [63:0] schedule_ms(bit [63:0] total);
    bit [63:0] lim;
    bit [63:0] ms_per_sec;
    lim = {32'd0, rate};
    ms_per_sec = 64'(bwcap_pkg::MS_PER_SEC);
    return (total / lim) * ms_per_sec + ((total % lim) * ms_per_sec) / lim;
  endfunction

  // Called per accepted request: updates the shadow state, queues a transfer's owed delay.
  function void note_request(logic kind, bit [31:0] nbytes);
    bit [63:0] elapsed;
    bit [63:0] due;
    bit [63:0] bound;
    bit [63:0] cap;
    if (kind == bwcap_pkg::KIND_TICK) begin
      now_ms = now_ms + 64'd1;
      return;
    end
    if (rate == 0) begin
      owed_delays.push_back(64'd0);
      return;
    end
    cap = 64'(bwcap_pkg::CREDIT_CAP_MS);
    elapsed = now_ms - origin_ms;
    bytes_sent = bytes_sent + {32'd0, nbytes};
    due = schedule_ms(bytes_sent);
    bound = due + cap;
    if (elapsed > bound) begin
      origin_ms = now_ms - due - cap;
      elapsed = bound;
    end
    owed_delays.push_back((due > elapsed) ? due - elapsed : 64'd0);
  endfunction

  function void check_result(logic [63:0] delay_ms);
    bit [63:0] owed;
    if (owed_delays.size() == 0) begin
      $display("%0t: unexpected delay_ms result, expected none, actual %0d", $time, delay_ms);
      errors++;
      return;
    end
    owed = owed_delays.pop_front();
    if (delay_ms !== owed) begin
      $display("%0t: delay_ms mismatch, expected %0d, actual %0d", $time, owed, delay_ms);
      errors++;
    end
  endfunction
endclass

module tb_bandwidth_limiter_credit_cap_core;
  import bwcap_pkg::*;

  // Number of random phases; each one starts with a fresh rate limit.
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned REQS_PER_PHASE = 160;
  // Length of the directed quiet stretch of ticks.
  localparam int unsigned QUIET_TICKS = 200;
  // Cycles allowed after the last owed delay before the register is rewritten.
  // A tick never leaves the idle state, so a short settle is plenty.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Wait at the end for longer than a limited transfer takes, so a stray extra result
  // would still be caught.
  localparam int unsigned DRAIN_CYCLES = 200;
  // The receiver's long hold-off, used to back the block up into its input.
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  // The slowest correct run has every transfer at full latency with the worst stalls;
  // this limit leaves a wide margin above it.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [31:0] byte_count
  logic [0:0]  in_tuser = '0;     // [0] kind: 0 = millisecond tick, 1 = transfer
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [63:0] delay_ms

  // Idling controls for the sender and the receiver. In the calm part at the end
  // neither side idles.
  bit          calm = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          want_long_hold = 1'b0;

  delay_scoreboard sb = new();

  bandwidth_limiter_credit_cap_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Every result handshake is checked against the oldest owed delay. The values read
  // here are the ones the block saw at this edge, since all inputs change by
  // nonblocking assignment.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  // The receiver stalls in short random bursts, and once in a long hold-off that the
  // stimulus asks for. The hold-off is counted here, in cycles, while the sender keeps
  // offering requests so that the block backs up and drops in_tready.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (want_long_hold) begin
        want_long_hold = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(1, 7);
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one request and returns in the time step of its handshake. The valid is
  // raised once and stays high across back-to-back requests; it drops only for an idle
  // burst or when the bench settles.
  task automatic send_request(logic kind, bit [31:0] nbytes);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 7);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= nbytes;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, nbytes);
  endtask

  // Drops the valid and waits until every owed delay has come back and the block has
  // had time to finish any tick still in progress.
  task automatic settle(int unsigned extra_cycles);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // The rate limit is only rewritten while the block is idle.
  task automatic write_limit(bit [31:0] value);
    settle(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
  endtask

  // Byte counts: mostly scaled to the limit so that the schedule moves a few
  // milliseconds per transfer, with the field extremes and full-range values mixed in.
  function automatic bit [31:0] pick_bytes(bit [31:0] lim);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, (lim < 100) ? 10 : lim / 50);
    endcase
  endfunction

  function automatic bit [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(1000, 1_000_000);
    endcase
  endfunction

  initial begin : stimulus
    bit [31:0]   lim;
    int unsigned tick_pct;
    int unsigned sent;
    int unsigned run_len;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Right after reset limiting is disabled: transfers owe nothing
    // and leave the state alone, and a tick ignores its byte count.
    send_request(KIND_XFER, 32'd0);
    send_request(KIND_XFER, 32'hFFFF_FFFF);
    send_request(KIND_TICK, 32'hFFFF_FFFF);

    // The slowest limit: one byte already owes a full second.
    write_limit(32'd1);
    send_request(KIND_XFER, 32'd1);
    send_request(KIND_TICK, 32'd0);
    send_request(KIND_TICK, 32'd0);
    send_request(KIND_XFER, 32'hFFFF_FFFF);

    // The fastest limit, with the largest and the smallest transfer.
    write_limit(32'hFFFF_FFFF);
    send_request(KIND_XFER, 32'hFFFF_FFFF);
    send_request(KIND_XFER, 32'd0);

    // Disabling and re-enabling keeps the clock, start time and byte total.
    write_limit(32'd0);
    send_request(KIND_XFER, 32'd5);
    send_request(KIND_TICK, 32'd0);
    write_limit(32'd1_000_000);
    send_request(KIND_XFER, 32'd1000);

    // A quiet stretch of ticks lets the clock run on; the byte total sent above is still far
    // ahead of schedule, so the next transfers owe time, and a large transfer adds more.
    repeat (QUIET_TICKS) send_request(KIND_TICK, $urandom);
    send_request(KIND_XFER, 32'd0);
    send_request(KIND_XFER, 32'd2000);
    send_request(KIND_TICK, 32'd0);
    send_request(KIND_XFER, 32'd50_000_000);

    // Random part: each phase picks a limit, a tick density and an idling mix. The
    // last phase runs without idling on either side.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      lim = pick_limit();
      write_limit(lim);
      calm = (phase == NUM_PHASES - 1);
      tick_pct = $urandom_range(40, 95);
      send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      sent = 0;
      if (phase == 1) begin
        // Transfers offered during the long hold-off back the block up into its input.
        want_long_hold = 1'b1;
        repeat (3) send_request(KIND_XFER, pick_bytes(lim));
        sent = 3;
      end
      while (sent < REQS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 3) begin
          // An idle stretch: a run of ticks with no traffic.
          run_len = $urandom_range(20, 300);
          repeat (run_len) send_request(KIND_TICK, $urandom);
          sent += run_len;
        end else begin
          if ($urandom_range(0, 99) < tick_pct) begin
            send_request(KIND_TICK, $urandom);
          end else begin
            send_request(KIND_XFER, pick_bytes(lim));
          end
          sent++;
        end
      end
    end

    settle(DRAIN_CYCLES);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bwcap_pkg.sv
hw/rtl/bwcap_datapath.sv
hw/rtl/bwcap_ctrl.sv
hw/rtl/bandwidth_limiter_credit_cap_core.sv
test/tb_bandwidth_limiter_credit_cap_core.sv
